FILE: rtl/svae_pkg.sv
// ----------------------------------------------------------------------------
// svae_pkg
// Shared types, constants and the control store of the setpoint
// velocity/acceleration estimator.
// ----------------------------------------------------------------------------
package svae_pkg;

	localparam int unsigned FRAC_BITS   = 16;
	localparam int unsigned ANGLE_W     = 32;
	localparam int unsigned RATE_W      = 16;
	localparam int unsigned LIMIT_W     = 31;
	localparam int unsigned CFG_IDX_W   = 2;
	localparam int unsigned CFG_DATA_W  = 32;

	// multiplier operands: 33 bit signed difference times 18 bit signed coefficient
	localparam int unsigned MUL_A_W     = ANGLE_W + 1;
	localparam int unsigned MUL_B_W     = RATE_W + 2;
	localparam int unsigned PROD_W      = MUL_A_W + MUL_B_W;

	// low-pass coefficients, Q0.16
	localparam int unsigned ALPHA_SHIFT = 16;
	localparam logic [MUL_B_W-1:0] ALPHA_Q = MUL_B_W'(45875);
	localparam logic [MUL_B_W-1:0] BETA_Q  = MUL_B_W'(65536 - 45875);

	// register indexes on the configuration channel
	localparam logic [CFG_IDX_W-1:0] REG_RATE_HZ   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_MAX_VEL   = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ACCEL = CFG_IDX_W'(2);

	// reset values of the configuration registers
	localparam logic [RATE_W-1:0] RATE_RST = RATE_W'(1000);
	localparam int unsigned VEL_RST_DEG    = 360;
	localparam int unsigned ACC_RST_DEG    = 1800;
	localparam logic [63:0] LIMIT_MAX      = 64'h7FFF_FFFF;
	localparam logic [63:0] VEL_RST_WIDE   = 64'(VEL_RST_DEG) << FRAC_BITS;
	localparam logic [63:0] ACC_RST_WIDE   = 64'(ACC_RST_DEG) << FRAC_BITS;
	localparam logic [LIMIT_W-1:0] VEL_RST =
		(VEL_RST_WIDE > LIMIT_MAX) ? LIMIT_MAX[LIMIT_W-1:0] : VEL_RST_WIDE[LIMIT_W-1:0];
	localparam logic [LIMIT_W-1:0] ACC_RST =
		(ACC_RST_WIDE > LIMIT_MAX) ? LIMIT_MAX[LIMIT_W-1:0] : ACC_RST_WIDE[LIMIT_W-1:0];

	// microcode
	localparam int unsigned STEPS  = 8;
	localparam int unsigned STEP_W = $clog2(STEPS);
	localparam logic [STEP_W-1:0] START_STEP = '0;

	typedef enum logic [1:0] {
		SEQ_NEXT,
		SEQ_WAIT_IN,
		SEQ_WAIT_OUT
	} seq_t;

	typedef enum logic [1:0] {
		MA_DIFF_TGT,
		MA_CLAMPED,
		MA_LAST_VEL,
		MA_DIFF_VEL
	} mula_t;

	typedef enum logic [1:0] {
		MB_RATE,
		MB_ALPHA,
		MB_BETA
	} mulb_t;

	typedef enum logic [2:0] {
		ALU_NOP,
		ALU_CLAMP_VEL,
		ALU_LOAD_SUM,
		ALU_FILTER,
		ALU_CLAMP_ACC
	} alu_t;

	typedef struct packed {
		seq_t  seq;
		logic  mul_en;
		mula_t mula;
		mulb_t mulb;
		alu_t  alu;
	} ctrl_t;

	localparam ctrl_t UCODE [STEPS] = '{
		'{seq: SEQ_WAIT_IN,  mul_en: 1'b0, mula: MA_DIFF_TGT, mulb: MB_RATE,  alu: ALU_NOP},
		'{seq: SEQ_NEXT,     mul_en: 1'b1, mula: MA_DIFF_TGT, mulb: MB_RATE,  alu: ALU_NOP},
		'{seq: SEQ_NEXT,     mul_en: 1'b0, mula: MA_DIFF_TGT, mulb: MB_RATE,  alu: ALU_CLAMP_VEL},
		'{seq: SEQ_NEXT,     mul_en: 1'b1, mula: MA_CLAMPED,  mulb: MB_ALPHA, alu: ALU_NOP},
		'{seq: SEQ_NEXT,     mul_en: 1'b1, mula: MA_LAST_VEL, mulb: MB_BETA,  alu: ALU_LOAD_SUM},
		'{seq: SEQ_NEXT,     mul_en: 1'b0, mula: MA_DIFF_TGT, mulb: MB_RATE,  alu: ALU_FILTER},
		'{seq: SEQ_NEXT,     mul_en: 1'b1, mula: MA_DIFF_VEL, mulb: MB_RATE,  alu: ALU_NOP},
		'{seq: SEQ_WAIT_OUT, mul_en: 1'b0, mula: MA_DIFF_TGT, mulb: MB_RATE,  alu: ALU_CLAMP_ACC}
	};

	// symmetric clamp of a wide product to +/- mag
	function automatic logic signed [ANGLE_W-1:0] clamp_mag(
		input logic signed [PROD_W-1:0] x,
		input logic [LIMIT_W-1:0] mag
	);
		logic signed [PROD_W-1:0] hi;
		logic signed [PROD_W-1:0] lo;
		hi = $signed({{(PROD_W-LIMIT_W){1'b0}}, mag});
		lo = -hi;
		if (x > hi)
			return hi[ANGLE_W-1:0];
		else if (x < lo)
			return lo[ANGLE_W-1:0];
		else
			return x[ANGLE_W-1:0];
	endfunction

endpackage

FILE: rtl/svae_if.sv
// ----------------------------------------------------------------------------
// svae channel interfaces
// Valid/ready channels for setpoint words, result words and register writes.
// ----------------------------------------------------------------------------
interface svae_in_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [svae_pkg::ANGLE_W-1:0]  target_angle;

	modport source (output valid, output target_angle, input ready);
	modport sink   (input valid, input target_angle, output ready);
endinterface

interface svae_out_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [svae_pkg::ANGLE_W-1:0]  velocity;
	logic signed [svae_pkg::ANGLE_W-1:0]  acceleration;

	modport source (output valid, output velocity, output acceleration, input ready);
	modport sink   (input valid, input velocity, input acceleration, output ready);
endinterface

interface svae_cfg_if;
	logic                                 valid;
	logic                                 ready;
	logic [svae_pkg::CFG_IDX_W-1:0]       index;
	logic [svae_pkg::CFG_DATA_W-1:0]      data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/setpoint_velocity_accel_estimator.sv
// ----------------------------------------------------------------------------
// setpoint_velocity_accel_estimator
// Finite-difference velocity and acceleration of a joint setpoint, with
// velocity clamp, first-order low-pass and acceleration clamp.
// ----------------------------------------------------------------------------
// Each setpoint word is taken in the first microcode step and then runs
// through seven microcode steps on a single shared 33x18 signed multiplier
// (rate, alpha and 1-alpha products); a new word is taken only after the
// previous word has finished its last step. The last step waits when the
// previous result word is still held in the output register. Register
// writes are taken at any time but are meant to happen while the block is idle.
module setpoint_velocity_accel_estimator (
	input  logic             clk,
	input  logic             arst_n,
	svae_in_if.sink          setpoint,
	svae_out_if.source       result,
	svae_cfg_if.sink         cfg
);

	// configuration
	logic [svae_pkg::RATE_W-1:0]   rate_q;
	logic [svae_pkg::LIMIT_W-1:0]  max_vel_q;
	logic [svae_pkg::LIMIT_W-1:0]  max_acc_q;

	// state kept across words
	logic signed [svae_pkg::ANGLE_W-1:0] last_tgt_q;
	logic signed [svae_pkg::ANGLE_W-1:0] last_vel_q;

	// datapath
	logic [svae_pkg::STEP_W-1:0]         step_q;
	logic signed [svae_pkg::ANGLE_W-1:0] tgt_q;
	logic signed [svae_pkg::ANGLE_W-1:0] x_q;
	logic signed [svae_pkg::ANGLE_W-1:0] vel_q;
	logic signed [svae_pkg::PROD_W-1:0]  prod_q;
	logic signed [svae_pkg::PROD_W-1:0]  sum_q;

	// output register
	logic                                out_valid_q;
	logic signed [svae_pkg::ANGLE_W-1:0] out_vel_q;
	logic signed [svae_pkg::ANGLE_W-1:0] out_acc_q;

	svae_pkg::ctrl_t                     ctrl;
	logic                                out_free;
	logic                                out_load;
	logic                                adv;
	logic signed [svae_pkg::MUL_A_W-1:0] mul_a;
	logic signed [svae_pkg::MUL_B_W-1:0] mul_b;
	logic signed [svae_pkg::PROD_W-1:0]  mul_p;
	logic signed [svae_pkg::PROD_W:0]    filt_sum;
	logic signed [svae_pkg::ANGLE_W-1:0] acc_clamped;

	assign ctrl     = svae_pkg::UCODE[step_q];
	assign out_free = !out_valid_q || result.ready;

	always_comb begin
		unique case (ctrl.seq)
			svae_pkg::SEQ_WAIT_IN:  adv = setpoint.valid;
			svae_pkg::SEQ_WAIT_OUT: adv = out_free;
			default:                adv = 1'b1;
		endcase
	end

	assign out_load       = adv && (ctrl.seq == svae_pkg::SEQ_WAIT_OUT);
	assign setpoint.ready = (ctrl.seq == svae_pkg::SEQ_WAIT_IN);
	assign cfg.ready      = 1'b1;

	// multiplier operand select
	always_comb begin
		unique case (ctrl.mula)
			svae_pkg::MA_DIFF_TGT: mul_a = {tgt_q[svae_pkg::ANGLE_W-1], tgt_q}
				- {last_tgt_q[svae_pkg::ANGLE_W-1], last_tgt_q};
			svae_pkg::MA_CLAMPED:  mul_a = {x_q[svae_pkg::ANGLE_W-1], x_q};
			svae_pkg::MA_LAST_VEL: mul_a = {last_vel_q[svae_pkg::ANGLE_W-1], last_vel_q};
			svae_pkg::MA_DIFF_VEL: mul_a = {vel_q[svae_pkg::ANGLE_W-1], vel_q}
				- {last_vel_q[svae_pkg::ANGLE_W-1], last_vel_q};
			default:               mul_a = '0;
		endcase
		unique case (ctrl.mulb)
			svae_pkg::MB_RATE:  mul_b = {2'b00, rate_q};
			svae_pkg::MB_ALPHA: mul_b = svae_pkg::ALPHA_Q;
			svae_pkg::MB_BETA:  mul_b = svae_pkg::BETA_Q;
			default:            mul_b = '0;
		endcase
	end

	assign mul_p       = mul_a * mul_b;
	assign filt_sum    = {sum_q[svae_pkg::PROD_W-1], sum_q}
		+ {prod_q[svae_pkg::PROD_W-1], prod_q};
	assign acc_clamped = svae_pkg::clamp_mag(prod_q, max_acc_q);

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q    <= svae_pkg::RATE_RST;
			max_vel_q <= svae_pkg::VEL_RST;
			max_acc_q <= svae_pkg::ACC_RST;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				svae_pkg::REG_RATE_HZ:   rate_q    <= cfg.data[svae_pkg::RATE_W-1:0];
				svae_pkg::REG_MAX_VEL:   max_vel_q <= cfg.data[svae_pkg::LIMIT_W-1:0];
				svae_pkg::REG_MAX_ACCEL: max_acc_q <= cfg.data[svae_pkg::LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= svae_pkg::START_STEP;
			last_tgt_q  <= '0;
			last_vel_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// a new word may replace the one leaving in the same cycle
			if (out_load)
				out_valid_q <= 1'b1;
			else if (result.valid && result.ready)
				out_valid_q <= 1'b0;
			if (adv) begin
				if (ctrl.seq == svae_pkg::SEQ_WAIT_OUT) begin
					step_q     <= svae_pkg::START_STEP;
					last_tgt_q <= tgt_q;
					last_vel_q <= vel_q;
				end else begin
					step_q <= step_q + 1'b1;
				end
			end
		end
	end

	// datapath payload
	always_ff @(posedge clk) begin
		if (adv) begin
			if (ctrl.seq == svae_pkg::SEQ_WAIT_IN)
				tgt_q <= setpoint.target_angle;
			if (ctrl.mul_en)
				prod_q <= mul_p;
			unique case (ctrl.alu)
				svae_pkg::ALU_CLAMP_VEL: x_q <= svae_pkg::clamp_mag(prod_q, max_vel_q);
				svae_pkg::ALU_LOAD_SUM:  sum_q <= prod_q;
				// arithmetic shift of alpha*raw + (1-alpha)*last
				svae_pkg::ALU_FILTER:
					vel_q <= filt_sum[svae_pkg::ALPHA_SHIFT +: svae_pkg::ANGLE_W];
				svae_pkg::ALU_CLAMP_ACC: begin
					out_vel_q <= vel_q;
					out_acc_q <= acc_clamped;
				end
				default: ;
			endcase
		end
	end

	assign result.valid        = out_valid_q;
	assign result.velocity     = out_vel_q;
	assign result.acceleration = out_acc_q;

endmodule

FILE: rtl/svae_chk.sv
// ----------------------------------------------------------------------------
// svae_chk
// Port-level checks of the estimator, bound to the top level.
// ----------------------------------------------------------------------------
module svae_chk (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	input  logic                                 in_ready,
	input  logic                                 out_valid,
	input  logic                                 out_ready,
	input  logic signed [svae_pkg::ANGLE_W-1:0]  velocity,
	input  logic signed [svae_pkg::ANGLE_W-1:0]  acceleration
);

	localparam logic [svae_pkg::ANGLE_W-1:0] MOST_NEG = {1'b1, {(svae_pkg::ANGLE_W-1){1'b0}}};

	// one word at a time: taking a word closes the input
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("setpoint taken while a word is in flight");

	// a new result shows only at the end of a word's work, never while idle
	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result appeared without a finished word");

	// clamps and the filter keep both outputs off the most negative code
	a_symmetric_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (velocity != MOST_NEG) && (acceleration != MOST_NEG))
		else $error("output outside symmetric range");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(velocity) && $stable(acceleration))
		else $error("stalled result word changed");

endmodule

bind setpoint_velocity_accel_estimator svae_chk u_svae_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (setpoint.valid),
	.in_ready     (setpoint.ready),
	.out_valid    (result.valid),
	.out_ready    (result.ready),
	.velocity     (result.velocity),
	.acceleration (result.acceleration)
);
